// File: hdl/assert_macros.svh
// Assertion macros for the checked module of the block, ift_ctrl.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that holds at every clock edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/ift_pkg.sv
// Types, constants and codes shared by the isometric fit-to-screen block.
package ift_pkg;

	localparam int SCR_W    = 13;
	localparam int COL_W    = 10;
	localparam int HGT_W    = 16;
	localparam int OUT_W    = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [SCR_W-1:0] SCREEN_WIDTH_RST  = 13'd1920;
	localparam logic [SCR_W-1:0] SCREEN_HEIGHT_RST = 13'd1080;

	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 1'b1;

	// round(sqrt(3)/2 * 2^32)
	localparam logic [31:0] COS30_Q32 = 32'd3719550787;

	localparam int DIV_DVD_W = SCR_W;
	localparam int DIV_DVS_W = 17;
	localparam int DIV_STEPS = DIV_DVD_W;

	typedef struct packed {
		logic                    operation;
		logic                    first_point;
		logic [COL_W-1:0]        grid_col;
		logic [COL_W-1:0]        grid_row;
		logic signed [HGT_W-1:0] height_value;
	} point_t;

	typedef struct packed {
		logic signed [OUT_W-1:0] out_x;
		logic signed [OUT_W-1:0] out_y;
		logic                    span_flag;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SPAN,
		ST_STARTX,
		ST_DIVX,
		ST_DIVY,
		ST_SHIFT_MUL,
		ST_SHIFT,
		ST_MUL,
		ST_WRITE
	} ctrl_state_t;

	typedef struct packed {
		logic take_point;
		logic span_load;
		logic div_start_x;
		logic cap_tw;
		logic div_start_y;
		logic cap_th;
		logic shift_mul;
		logic shift_load;
		logic place_mul;
		logic out_load;
	} ctrl_cmd_t;

	typedef struct packed {
		logic div_done;
	} dp_status_t;

endpackage

// File: hdl/ift_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
module ift_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [ift_pkg::DIV_DVD_W-1:0]  dividend,
	input  logic [ift_pkg::DIV_DVS_W-1:0]  divisor,
	output logic [ift_pkg::DIV_DVD_W-1:0]  quotient,
	output logic                           done
);
	import ift_pkg::*;

	localparam int CNT_W = $clog2(DIV_STEPS + 1);

	logic [DIV_DVS_W-1:0] rem_q;
	logic [DIV_DVD_W-1:0] quo_q;
	logic [DIV_DVS_W-1:0] dvs_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic [DIV_DVS_W:0]   trial;
	logic [DIV_DVS_W:0]   diff;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_DVD_W-1]};
	assign diff  = trial - {1'b0, dvs_q};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= !start && busy_q && (cnt_q == CNT_W'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(DIV_STEPS);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1))
					busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= fits ? diff[DIV_DVS_W-1:0] : trial[DIV_DVS_W-1:0];
			quo_q <= {quo_q[DIV_DVD_W-2:0], fits};
		end
	end

	assign quotient = quo_q;
	assign done     = done_q;

endmodule

// File: hdl/ift_dpath.sv
// Datapath: projection, bounding box, tile fit, screen mapping and result register.
module ift_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  ift_pkg::point_t                    point,
	input  logic                               cfg_wen,
	input  logic [ift_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ift_pkg::SCR_W-1:0]          cfg_wdata,
	input  ift_pkg::ctrl_cmd_t                 cmd,
	output ift_pkg::dp_status_t                status,
	output ift_pkg::result_t                   result
);
	import ift_pkg::*;

	function automatic logic signed [OUT_W-1:0] sat16(input logic signed [33:0] v);
		logic signed [OUT_W-1:0] r;
		if (v > 34'sd32767)
			r = 16'sh7fff;
		else if (v < -34'sd32768)
			r = 16'sh8000;
		else
			r = v[OUT_W-1:0];
		return r;
	endfunction

	logic [SCR_W-1:0]         sw_q, sh_q;
	logic signed [10:0]       lx_q, gx_q, px_q;
	logic signed [16:0]       ly_q, gy_q, py_q;
	logic                     op_q, first_q;
	logic [10:0]              spx_q;
	logic [16:0]              spy_q;
	logic                     flag_q;
	logic [SCR_W-1:0]         tw_q, ts_q;
	logic signed [25:0]       prx_q;
	logic signed [31:0]       pry_q;
	logic signed [31:0]       shift_x_q, shift_y_q;
	logic signed [24:0]       mx_q;
	logic signed [30:0]       my_q;
	result_t                  result_q;

	logic signed [10:0]       diff_cr;
	logic [COL_W-1:0]         mag;
	logic [41:0]              cos_prod;
	logic [9:0]               cos_q;
	logic signed [10:0]       px_n;
	logic signed [17:0]       vsum, vadj;
	logic signed [16:0]       py_n;
	logic signed [11:0]       spx_d, sumx;
	logic signed [17:0]       spy_d, sumy;
	logic                     zx, zy;
	logic signed [25:0]       halfx;
	logic signed [31:0]       halfy;
	logic signed [33:0]       scr_x, scr_y;
	logic                     div_start;
	logic [DIV_DVD_W-1:0]     div_dvd, div_quo;
	logic [DIV_DVS_W-1:0]     div_dvs;
	logic                     div_done;

	assign diff_cr  = $signed({1'b0, point.grid_col}) - $signed({1'b0, point.grid_row});
	assign mag      = diff_cr[10] ? COL_W'(-diff_cr) : diff_cr[COL_W-1:0];
	assign cos_prod = mag * COS30_Q32;
	assign cos_q    = cos_prod[41:32];
	assign px_n     = diff_cr[10] ? -$signed({1'b0, cos_q}) : $signed({1'b0, cos_q});
	assign vsum     = $signed({8'b0, point.grid_col}) + $signed({8'b0, point.grid_row})
	                  - (18'(point.height_value) <<< 1);
	assign vadj     = vsum + $signed({17'b0, vsum[17]});
	assign py_n     = 17'(vadj >>> 1);

	assign spx_d = 12'(gx_q) - 12'(lx_q);
	assign spy_d = 18'(gy_q) - 18'(ly_q);
	assign zx    = spx_d[11] || (spx_d == 12'sd0);
	assign zy    = spy_d[17] || (spy_d == 18'sd0);
	assign sumx  = 12'(gx_q) + 12'(lx_q);
	assign sumy  = 18'(gy_q) + 18'(ly_q);

	assign halfx = (prx_q + $signed({25'b0, prx_q[25]})) >>> 1;
	assign halfy = (pry_q + $signed({31'b0, pry_q[31]})) >>> 1;

	assign scr_x = 34'(mx_q) + 34'(shift_x_q);
	assign scr_y = 34'(my_q) + 34'(shift_y_q);

	assign div_start = cmd.div_start_x | cmd.div_start_y;
	assign div_dvd   = cmd.div_start_y ? sh_q : sw_q;
	assign div_dvs   = cmd.div_start_y ? spy_q : {6'b0, spx_q};

	ift_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.quotient (div_quo),
		.done     (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sw_q      <= SCREEN_WIDTH_RST;
			sh_q      <= SCREEN_HEIGHT_RST;
			lx_q      <= '0;
			gx_q      <= '0;
			ly_q      <= '0;
			gy_q      <= '0;
			ts_q      <= '0;
			shift_x_q <= '0;
			shift_y_q <= '0;
			flag_q    <= 1'b0;
		end else begin
			if (cfg_wen) begin
				case (cfg_index)
					REG_SCREEN_WIDTH:  sw_q <= cfg_wdata;
					REG_SCREEN_HEIGHT: sh_q <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.out_load && !op_q) begin
				if (first_q) begin
					lx_q <= px_q;
					gx_q <= px_q;
					ly_q <= py_q;
					gy_q <= py_q;
				end else begin
					if (px_q > gx_q) gx_q <= px_q;
					if (px_q < lx_q) lx_q <= px_q;
					if (py_q > gy_q) gy_q <= py_q;
					if (py_q < ly_q) ly_q <= py_q;
				end
			end
			if (cmd.span_load)
				flag_q <= zx | zy;
			if (cmd.cap_th)
				ts_q <= (tw_q <= div_quo) ? tw_q : div_quo;
			if (cmd.shift_load) begin
				shift_x_q <= $signed({20'b0, sw_q[SCR_W-1:1]}) - 32'(halfx);
				shift_y_q <= $signed({20'b0, sh_q[SCR_W-1:1]}) - halfy;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.take_point) begin
			px_q    <= px_n;
			py_q    <= py_n;
			op_q    <= point.operation;
			first_q <= point.first_point;
		end
		if (cmd.span_load) begin
			spx_q <= zx ? 11'd1 : spx_d[10:0];
			spy_q <= zy ? 17'd1 : spy_d[16:0];
		end
		if (cmd.cap_tw)
			tw_q <= div_quo;
		if (cmd.shift_mul) begin
			prx_q <= sumx * $signed({1'b0, ts_q});
			pry_q <= sumy * $signed({1'b0, ts_q});
		end
		if (cmd.place_mul) begin
			mx_q <= px_q * $signed({1'b0, ts_q});
			my_q <= py_q * $signed({1'b0, ts_q});
		end
		if (cmd.out_load) begin
			if (op_q) begin
				result_q.out_x     <= sat16(scr_x);
				result_q.out_y     <= sat16(scr_y);
				result_q.span_flag <= flag_q;
			end else begin
				result_q.out_x     <= sat16(34'(px_q));
				result_q.out_y     <= sat16(34'(py_q));
				result_q.span_flag <= 1'b0;
			end
		end
	end

	assign status.div_done = div_done;
	assign result          = result_q;

endmodule

// File: hdl/ift_ctrl.sv
// Controller state machine: item handshakes and sequencing of the datapath.
`include "assert_macros.svh"

module ift_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 point_valid,
	output logic                 point_ready,
	input  logic                 point_op,
	input  logic                 point_first,
	output logic                 result_valid,
	input  logic                 result_ready,
	output ift_pkg::ctrl_cmd_t   cmd,
	input  ift_pkg::dp_status_t  status
);
	import ift_pkg::*;

	ctrl_state_t state_q, state_d;
	logic        result_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			result_valid_q <= 1'b0;
		end else begin
			state_q        <= state_d;
			result_valid_q <= cmd.out_load | (result_valid_q & ~result_ready);
		end
	end

	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		point_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				point_ready = 1'b1;
				if (point_valid) begin
					cmd.take_point = 1'b1;
					if (!point_op)
						state_d = ST_WRITE;
					else if (point_first)
						state_d = ST_SPAN;
					else
						state_d = ST_MUL;
				end
			end
			ST_SPAN: begin
				cmd.span_load = 1'b1;
				state_d       = ST_STARTX;
			end
			ST_STARTX: begin
				cmd.div_start_x = 1'b1;
				state_d         = ST_DIVX;
			end
			ST_DIVX: begin
				if (status.div_done) begin
					cmd.cap_tw      = 1'b1;
					cmd.div_start_y = 1'b1;
					state_d         = ST_DIVY;
				end
			end
			ST_DIVY: begin
				if (status.div_done) begin
					cmd.cap_th = 1'b1;
					state_d    = ST_SHIFT_MUL;
				end
			end
			ST_SHIFT_MUL: begin
				cmd.shift_mul = 1'b1;
				state_d       = ST_SHIFT;
			end
			ST_SHIFT: begin
				cmd.shift_load = 1'b1;
				state_d        = ST_MUL;
			end
			ST_MUL: begin
				cmd.place_mul = 1'b1;
				state_d       = ST_WRITE;
			end
			ST_WRITE: begin
				if (!result_valid_q || result_ready) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign result_valid = result_valid_q;

	`ASSERT_IMPLIES(a_no_overwrite, cmd.out_load, !result_valid_q || result_ready, "result overwritten before taken")
	`ASSERT_NEXT(a_busy_after_take, point_valid && point_ready, state_q != ST_IDLE, "idle after taking an item")
	`ASSERT_NEXT(a_result_shown, cmd.out_load, result_valid, "loaded result not presented")

endmodule

// File: hdl/isometric_fit_to_screen.sv
// Top level of the isometric projection and screen fit block.
//
//   channel  direction  handshake                  payload
//   point    in         point_valid / point_ready  ift_pkg::point_t
//   result   out        result_valid / result_ready ift_pkg::result_t
//   cfg      in         cfg_wen (no wait)          cfg_index, cfg_wdata
//
// Measure item: write state. Place item: multiply, then write; the first item
// of a place pass adds two 13-step runs of the shared divider and the shift.
// One item is in work at a time; the next is taken while a result waits.
// Reset sets the screen to 1920 x 1080 and clears box, tile size and offsets.
// A stalled result holds the last step of the following item until taken.
module isometric_fit_to_screen (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           point_valid,
	output logic                           point_ready,
	input  ift_pkg::point_t                point,
	output logic                           result_valid,
	input  logic                           result_ready,
	output ift_pkg::result_t               result,
	input  logic                           cfg_wen,
	input  logic [ift_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [ift_pkg::SCR_W-1:0]      cfg_wdata
);
	import ift_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	ift_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point_op     (point.operation),
		.point_first  (point.first_point),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.cmd          (cmd),
		.status       (status)
	);

	ift_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.point     (point),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cmd       (cmd),
		.status    (status),
		.result    (result)
	);

endmodule

// File: bench/tb_isometric_fit_to_screen.sv
// Self-checking bench for the isometric fit-to-screen block: directed items and random passes against a predictor.
module tb_isometric_fit_to_screen;
	timeunit 1ns;
	timeprecision 1ps;

	import ift_pkg::*;

	localparam logic OP_MEASURE = 1'b0;
	localparam logic OP_PLACE   = 1'b1;
	localparam longint unsigned COS30_FRAC = 64'd3719550787;

	logic                 clk;
	logic                 arst_n;
	logic                 point_valid;
	logic                 point_ready;
	point_t               point;
	logic                 result_valid;
	logic                 result_ready;
	result_t              result;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [SCR_W-1:0]     cfg_wdata;

	point_t  points_to_send[$];
	result_t screen_due[$];
	result_t want;
	bit      point_done;
	bit      idling_on;
	int      send_gap;
	int      stall_left;
	int      failures;

	int screen_w, screen_h;
	int box_min_x, box_max_x, box_min_y, box_max_y;
	int tile, shift_x, shift_y;
	bit zero_span;

	isometric_fit_to_screen dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.point_valid  (point_valid),
		.point_ready  (point_ready),
		.point        (point),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_wen      (cfg_wen),
		.cfg_index    (cfg_index),
		.cfg_wdata    (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic logic signed [15:0] clip16(longint v);
		if (v > 32767) begin
			return 16'sd32767;
		end
		if (v < -32768) begin
			return -16'sd32768;
		end
		return v[15:0];
	endfunction

	function automatic result_t fit_point(point_t p);
		int col, row, hgt, diff, qx, px, py;
		longint unsigned mag;
		longint spanx, spany, tw, th;
		result_t r;
		col = int'(p.grid_col);
		row = int'(p.grid_row);
		hgt = int'($signed(p.height_value));
		diff = col - row;
		mag = (diff < 0) ? longint'(-diff) : longint'(diff);
		qx = int'((mag * COS30_FRAC) >> 32);
		px = (diff < 0) ? -qx : qx;
		py = (col + row - 2 * hgt) / 2;
		if (p.operation == OP_MEASURE) begin
			if (p.first_point) begin
				box_min_x = px;
				box_max_x = px;
				box_min_y = py;
				box_max_y = py;
			end else begin
				if (px > box_max_x) box_max_x = px;
				if (px < box_min_x) box_min_x = px;
				if (py > box_max_y) box_max_y = py;
				if (py < box_min_y) box_min_y = py;
			end
			r.out_x = clip16(longint'(px));
			r.out_y = clip16(longint'(py));
			r.span_flag = 1'b0;
			return r;
		end
		if (p.first_point) begin
			spanx = longint'(box_max_x) - box_min_x;
			spany = longint'(box_max_y) - box_min_y;
			zero_span = 1'b0;
			if (spanx <= 0) begin
				spanx = 1;
				zero_span = 1'b1;
			end
			if (spany <= 0) begin
				spany = 1;
				zero_span = 1'b1;
			end
			tw = longint'(screen_w) / spanx;
			th = longint'(screen_h) / spany;
			tile = int'((tw <= th) ? tw : th) & 16'h3FFF;
			shift_x = int'(longint'(screen_w / 2)
				- ((longint'(box_max_x) + box_min_x) * tile) / 2);
			shift_y = int'(longint'(screen_h / 2)
				- ((longint'(box_max_y) + box_min_y) * tile) / 2);
		end
		r.out_x = clip16(longint'(px) * tile + shift_x);
		r.out_y = clip16(longint'(py) * tile + shift_y);
		r.span_flag = zero_span;
		return r;
	endfunction

	// Predict each item as the block takes it.
	always @(posedge clk) begin
		if (arst_n && point_valid && point_ready) begin
			screen_due.push_back(fit_point(point));
			point_done = 1'b1;
		end
	end

	always @(negedge clk) begin
		if (arst_n && !(point_valid && !point_done)) begin
			point_done = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				point_valid <= 1'b0;
			end else if (points_to_send.size() > 0) begin
				point <= points_to_send.pop_front();
				point_valid <= 1'b1;
				if (idling_on && $urandom_range(0, 5) == 0)
					send_gap = $urandom_range(1, 3);
			end else begin
				point_valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		if (arst_n) begin
			if (stall_left > 0) begin
				stall_left--;
				result_ready <= 1'b0;
			end else begin
				result_ready <= 1'b1;
				if (idling_on && $urandom_range(0, 5) == 0)
					stall_left = $urandom_range(1, 3);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && result_ready) begin
			if (screen_due.size() == 0) begin
				$display("%0t: unexpected result x %0d y %0d flag %0b", $time,
					$signed(result.out_x), $signed(result.out_y), result.span_flag);
				failures++;
			end else begin
				want = screen_due.pop_front();
				if (result.out_x !== want.out_x) begin
					$display("%0t: out_x expected %0d got %0d", $time,
						$signed(want.out_x), $signed(result.out_x));
					failures++;
				end
				if (result.out_y !== want.out_y) begin
					$display("%0t: out_y expected %0d got %0d", $time,
						$signed(want.out_y), $signed(result.out_y));
					failures++;
				end
				if (result.span_flag !== want.span_flag) begin
					$display("%0t: span_flag expected %0b got %0b", $time,
						want.span_flag, result.span_flag);
					failures++;
				end
			end
		end
	end

	function automatic point_t mk_point(logic op, logic first, int col, int row, int hgt);
		point_t p;
		p.operation = op;
		p.first_point = first;
		p.grid_col = col[COL_W-1:0];
		p.grid_row = row[COL_W-1:0];
		p.height_value = hgt[HGT_W-1:0];
		return p;
	endfunction

	task automatic drain();
		while (points_to_send.size() != 0 || point_valid || screen_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_screen(int wv, int hv);
		drain();
		@(negedge clk);
		cfg_wen <= 1'b1;
		cfg_index <= REG_SCREEN_WIDTH;
		cfg_wdata <= wv[SCR_W-1:0];
		@(negedge clk);
		cfg_index <= REG_SCREEN_HEIGHT;
		cfg_wdata <= hv[SCR_W-1:0];
		@(negedge clk);
		cfg_wen <= 1'b0;
		screen_w = wv & 32'h1FFF;
		screen_h = hv & 32'h1FFF;
	endtask

	task automatic add_passes(int count);
		int left, n, reach, h_reach, base_c, base_r, hgt;
		left = count;
		while (left > 0) begin
			if ($urandom_range(0, 9) == 0) begin
				points_to_send.push_back(mk_point(1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)),
					$urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(0, 65535)));
				left--;
			end else begin
				case ($urandom_range(0, 3))
					0: reach = 0;
					1: reach = 3;
					2: reach = 40;
					default: reach = 1023;
				endcase
				case ($urandom_range(0, 3))
					0: h_reach = 0;
					1: h_reach = 4;
					2: h_reach = 300;
					default: h_reach = 32767;
				endcase
				base_c = $urandom_range(0, 1023 - reach);
				base_r = $urandom_range(0, 1023 - reach);
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					hgt = $urandom_range(0, 2 * h_reach) - h_reach;
					points_to_send.push_back(mk_point(OP_MEASURE, i == 0,
						base_c + $urandom_range(0, reach), base_r + $urandom_range(0, reach), hgt));
				end
				left -= n;
				n = $urandom_range(1, 8);
				for (int i = 0; i < n; i++) begin
					hgt = $urandom_range(0, 2 * h_reach) - h_reach;
					points_to_send.push_back(mk_point(OP_PLACE,
						i == 0 && $urandom_range(0, 7) != 0,
						base_c + $urandom_range(0, reach), base_r + $urandom_range(0, reach), hgt));
				end
				left -= n;
			end
		end
	endtask

	initial begin
		int wide[6];
		int high[6];
		arst_n = 1'b0;
		point_valid = 1'b0;
		point = '0;
		result_ready = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		point_done = 1'b0;
		idling_on = 1'b1;
		send_gap = 0;
		stall_left = 0;
		failures = 0;
		screen_w = 1920;
		screen_h = 1080;
		box_min_x = 0;
		box_max_x = 0;
		box_min_y = 0;
		box_max_y = 0;
		tile = 0;
		shift_x = 0;
		shift_y = 0;
		zero_span = 1'b0;
		wide = '{8191, 1, 0, 8191, 1920, $urandom_range(1, 8191)};
		high = '{8191, 1, 8191, 0, 1080, $urandom_range(1, 8191)};

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// place before any tile computation, then measure widening from reset box
		points_to_send.push_back(mk_point(OP_PLACE, 1'b0, 1023, 0, -32768));
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b0, 5, 3, 0));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b1, 0, 0, 0));
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b1, 1023, 0, -32768));
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b0, 0, 1023, 32767));
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b0, 1023, 1023, 0));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b1, 512, 511, -1));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b0, 0, 1023, 32767));
		// tiny box: large tile, saturating placements
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b1, 10, 10, 0));
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b0, 12, 10, 0));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b1, 10, 10, 0));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b0, 1023, 0, -32768));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b0, 0, 1023, 32767));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b0, 682, 341, 21845));
		// single point: both spans zero
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b1, 7, 7, 3));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b1, 7, 7, 3));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b0, 8, 6, -2));
		// only the y span zero
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b1, 0, 0, 0));
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b0, 2, 0, 1));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b1, 2, 0, 1));
		// only the x span zero
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b1, 300, 300, 0));
		points_to_send.push_back(mk_point(OP_MEASURE, 1'b0, 301, 301, -5));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b1, 300, 300, 0));
		points_to_send.push_back(mk_point(OP_PLACE, 1'b0, 341, 682, -21846));

		for (int k = 0; k < 6; k++) begin
			set_screen(wide[k], high[k]);
			add_passes(130);
		end
		drain();
		set_screen($urandom_range(1, 8191), $urandom_range(1, 8191));
		idling_on = 1'b0;
		add_passes(130);
		drain();

		if (failures == 0) begin
			$display("isometric_fit_to_screen verification clean");
		end else begin
			$display("isometric_fit_to_screen verification failed");
		end
		$finish;
	end

	initial begin
		#20ms;
		$display("isometric_fit_to_screen verification failed");
		$finish;
	end

endmodule

// File: isometric_fit_to_screen.f
+incdir+hdl
hdl/ift_pkg.sv
hdl/ift_div.sv
hdl/ift_dpath.sv
hdl/ift_ctrl.sv
hdl/isometric_fit_to_screen.sv
bench/tb_isometric_fit_to_screen.sv
